// ===== rtl/swbm_pkg.sv =====
// swbm_pkg: shared types and fixed widths for the sliding window best match block.
// No dependencies; used through scoped names by every module under rtl/ but swbm_checker.
`default_nettype none
package swbm_pkg;
	localparam int CHAR_W  = 8;
	localparam int CNT_W   = 4;
	localparam int PAT_W   = 64;
	localparam int IDX_W   = 2;
	localparam int QADDR_W = 2;

	localparam logic [IDX_W-1:0] REG_PATTERN_CHARS = 2'd0;
	localparam logic [IDX_W-1:0] REG_PATTERN_LEN   = 2'd1;

	localparam logic [CNT_W-1:0] PATTERN_LEN_RST = 4'd3;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             scored;
		logic             last;
	} swbm_entry_t;
endpackage
`default_nettype wire

// ===== rtl/sliding_window_best_match.sv =====
// sliding_window_best_match: top level; config registers, front, queue, back.
// Depends on swbm_pkg, swbm_front, swbm_queue, swbm_back.
//
// channel | handshake              | payload
// in      | in_valid / in_ready    | genome_char[7:0], genome_last
// out     | out_valid / out_ready  | best_matches[3:0], window_seen
// cfg     | cfg_valid / cfg_ready  | cfg_index[1:0], cfg_data[63:0]
//
// One word per cycle unless the queue is full; a word's compare and count
// happen in the cycle it is taken, the best count is updated as its entry
// is popped. A result appears in the cycle after its last word leaves the queue.
// Reset clears window, counters, queue and out_valid; pattern_len resets to 3.
// A stalled result blocks only last words; other words keep draining.
`default_nettype none
module sliding_window_best_match #(
	parameter int PAT_MAX = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [swbm_pkg::CHAR_W-1:0]   genome_char,
	input  wire logic                          genome_last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [swbm_pkg::CNT_W-1:0]         best_matches,
	output logic                               window_seen,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [swbm_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [swbm_pkg::PAT_W-1:0]    cfg_data
);
	logic [swbm_pkg::PAT_W-1:0] pattern_chars_q;
	logic [swbm_pkg::CNT_W-1:0] pattern_len_q;
	logic                       take;
	logic                       q_full;
	logic                       q_nonempty;
	logic                       q_pop;
	swbm_pkg::swbm_entry_t      f_entry;
	swbm_pkg::swbm_entry_t      q_head;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign take      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_chars_q <= '0;
			pattern_len_q   <= swbm_pkg::PATTERN_LEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				swbm_pkg::REG_PATTERN_CHARS: pattern_chars_q <= cfg_data;
				swbm_pkg::REG_PATTERN_LEN:   pattern_len_q <= cfg_data[swbm_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	swbm_front #(.PAT_MAX(PAT_MAX)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.genome_char  (genome_char),
		.genome_last  (genome_last),
		.pattern_chars(pattern_chars_q),
		.pattern_len  (pattern_len_q),
		.entry        (f_entry)
	);

	swbm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_entry(f_entry),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	swbm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.nonempty    (q_nonempty),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.best_matches(best_matches),
		.window_seen (window_seen)
	);
endmodule
`default_nettype wire

// ===== rtl/swbm_front.sv =====
// swbm_front: character window, per-word position compare and match count.
// Depends on swbm_pkg; pushes one swbm_entry_t per accepted word.
`default_nettype none
module swbm_front #(
	parameter int PAT_MAX = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       take,
	input  wire logic [swbm_pkg::CHAR_W-1:0] genome_char,
	input  wire logic                       genome_last,
	input  wire logic [swbm_pkg::PAT_W-1:0]  pattern_chars,
	input  wire logic [swbm_pkg::CNT_W-1:0]  pattern_len,
	output swbm_pkg::swbm_entry_t           entry
);
	localparam logic [swbm_pkg::CNT_W-1:0] PMAX = swbm_pkg::CNT_W'(PAT_MAX);

	logic [swbm_pkg::CHAR_W-1:0] win_q [PAT_MAX];
	logic [swbm_pkg::CHAR_W-1:0] win_next [PAT_MAX];
	logic [swbm_pkg::CNT_W-1:0]  seen_q;
	logic [swbm_pkg::CNT_W-1:0]  seen_next;
	logic [swbm_pkg::CNT_W-1:0]  eff_len;
	logic [PAT_MAX-1:0]          hit;
	logic [swbm_pkg::CNT_W-1:0]  cnt;

	always_comb begin
		win_next[0] = genome_char;
		for (int j = 1; j < PAT_MAX; j++) begin
			win_next[j] = win_q[j-1];
		end
		seen_next = (seen_q < PMAX) ? seen_q + 4'd1 : seen_q;
		eff_len = (pattern_len > PMAX) ? PMAX : pattern_len;
	end

	// position k of the window is the word taken len-1-k words ago
	always_comb begin
		hit = '0;
		for (int k = 0; k < PAT_MAX; k++) begin
			for (int j = 0; j < PAT_MAX; j++) begin
				if (swbm_pkg::CNT_W'(j) + swbm_pkg::CNT_W'(k) + 4'd1 == eff_len) begin
					hit[k] = (win_next[j] == pattern_chars[8*k +: 8]);
				end
			end
		end
		cnt = '0;
		for (int k = 0; k < PAT_MAX; k++) begin
			cnt = cnt + swbm_pkg::CNT_W'(hit[k]);
		end
	end

	always_comb begin
		entry.scored = (eff_len != '0) && (seen_next >= eff_len);
		entry.cnt    = cnt;
		entry.last   = genome_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int j = 0; j < PAT_MAX; j++) begin
				win_q[j] <= '0;
			end
		end else if (take) begin
			if (genome_last) begin
				seen_q <= '0;
				for (int j = 0; j < PAT_MAX; j++) begin
					win_q[j] <= '0;
				end
			end else begin
				seen_q <= seen_next;
				for (int j = 0; j < PAT_MAX; j++) begin
					win_q[j] <= win_next[j];
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/swbm_queue.sv =====
// swbm_queue: four-entry queue of swbm_entry_t between front and back.
// Depends on swbm_pkg.
`default_nettype none
module swbm_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire swbm_pkg::swbm_entry_t push_entry,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      nonempty,
	output swbm_pkg::swbm_entry_t     head
);
	localparam int DEPTH = 1 << swbm_pkg::QADDR_W;

	swbm_pkg::swbm_entry_t          mem_q [DEPTH];
	logic [swbm_pkg::QADDR_W-1:0]   wr_q;
	logic [swbm_pkg::QADDR_W-1:0]   rd_q;
	logic [swbm_pkg::QADDR_W:0]     cnt_q;

	assign full     = (cnt_q == (swbm_pkg::QADDR_W+1)'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/swbm_back.sv =====
// swbm_back: running best count per genome and the registered result word.
// Depends on swbm_pkg; drains swbm_queue.
`default_nettype none
module swbm_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      nonempty,
	input  wire swbm_pkg::swbm_entry_t     head,
	output logic                           pop,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [swbm_pkg::CNT_W-1:0]     best_matches,
	output logic                           window_seen
);
	logic [swbm_pkg::CNT_W-1:0] best_q;
	logic [swbm_pkg::CNT_W-1:0] best_next;
	logic                       out_valid_q;
	logic [swbm_pkg::CNT_W-1:0] best_out_q;
	logic                       seen_out_q;

	assign pop = nonempty && (!head.last || !out_valid_q || out_ready);
	assign best_next = (head.scored && head.cnt > best_q) ? head.cnt : best_q;

	assign out_valid    = out_valid_q;
	assign best_matches = best_out_q;
	assign window_seen  = seen_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				best_q <= head.last ? '0 : best_next;
			end
			if (pop && head.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			best_out_q <= best_next;
			seen_out_q <= head.scored;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/swbm_checker.sv =====
// swbm_checker: port-level assertions for sliding_window_best_match.
// Depends on the top level's ports only; bound in at the end of this file.
`default_nettype none
module swbm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [3:0] best_matches,
	input wire logic       window_seen
);
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_matches <= 4'd8)
		else $error("best_matches above eight");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({best_matches, window_seen}))
		else $error("result word unknown while valid");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_matches)
			&& $stable(window_seen))
		else $error("result word changed while stalled");
endmodule

bind sliding_window_best_match swbm_checker u_swbm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.best_matches(best_matches),
	.window_seen (window_seen)
);
`default_nettype wire
